// ----- design/fnv_double_hash_table_lookup_core_defines.svh -----
// Assertion macros for the hash lookup core.
`ifndef FNV_DOUBLE_HASH_TABLE_LOOKUP_CORE_DEFINES_SVH
`define FNV_DOUBLE_HASH_TABLE_LOOKUP_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define FDH_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");
// Next-cycle implication.
`define FDH_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");
`endif

// ----- design/fdh_pkg.sv -----
// Shared types and constants for the hash lookup core.
`default_nettype none
package fdh_pkg;
  localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HASH, ST_MOD1, ST_RD, ST_CHK, ST_STEP, ST_MOD2, ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } mod_ctl_t;
endpackage
`default_nettype wire

// ----- design/fdh_mod.sv -----
// Restoring modulo unit, one quotient bit per cycle.
`default_nettype none
module fdh_mod #(
  parameter int DW = 33,
  parameter int MW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [MW-1:0] divisor,
  output fdh_pkg::mod_ctl_t  ctl,
  output logic [MW-1:0]      remainder
);
  localparam int CW = $clog2(DW + 1);
  logic [DW-1:0] shreg;
  logic [MW:0] rem;
  logic [CW-1:0] cnt;
  logic [MW:0] trial;

  assign trial = {rem[MW-1:0], shreg[DW-1]};
  assign remainder = rem[MW-1:0];
  assign ctl.start = start;
  assign ctl.busy = (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(DW);
      shreg <= dividend;
      rem <= '0;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
      shreg <= {shreg[DW-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) rem <= trial - {1'b0, divisor};
      else rem <= trial;
    end
  end
endmodule
`default_nettype wire

// ----- design/fnv_double_hash_table_lookup_core.sv -----
// Top level of the FNV-1 double-hash table lookup core.
// Channel  Dir  Fields (low bit up)
// s_axis   in   tuser: req_type; tdata: slot_index, key_value, link_value (88 bits)
// m_axis   out  tdata: match_slot (16 bits)
// cfg      in   wr_en/wr_data: primary_slots
// After reset the tables are cleared one slot a cycle, with s_axis not ready until done.
// A write is stored when it is accepted. A lookup (a zero key skips to the result) is hashed
// over KEY_BYTES key bytes and reduced by a modulo (33 divide steps). Each table read (probe
// or link hop) has a read and a check state; each further probe adds a step and a modulo.
// Result waits in an output register; the next item is taken once it has been transferred.
`default_nettype none
module fnv_double_hash_table_lookup_core #(
  parameter int TABLE_SIZE = 1024,
  parameter int KEY_BYTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [87:0] s_axis_tdata,  // slot_index, key_value, link_value
  input  wire logic        s_axis_tuser,  // req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // match_slot
  input  wire logic        cfg_wr_en,
  input  wire logic [10:0] cfg_wr_data
);
  localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int PW = $clog2(TABLE_SIZE + 1);
  localparam int BW = $clog2(KEY_BYTES + 1);
  localparam logic [63:0] KMASK = (KEY_BYTES >= 8) ? '1 : ((64'd1 << (8*KEY_BYTES)) - 64'd1);

  logic [63:0] key_mem [TABLE_SIZE];
  logic [10:0] link_mem [TABLE_SIZE];

  fdh_pkg::state_t state, state_next;
  logic [10:0] primary_slots;
  logic [PW-1:0] k;
  logic [63:0] key;
  logic [31:0] h;
  logic [32:0] h1;
  logic [PW-1:0] h2, p;
  logic [BW-1:0] bcnt;
  logic [PW-1:0] cnt;
  logic in_link;
  logic [63:0] rd_key;
  logic [10:0] rd_link;
  logic [10:0] result;
  logic [AW-1:0] clr;
  logic mod_start;
  fdh_pkg::mod_ctl_t mctl;
  logic [PW-1:0] mrem;
  logic [9:0] in_slot;
  logic [63:0] in_key;
  logic [10:0] in_link_val;
  logic hit, empty;

  assign in_slot = s_axis_tdata[9:0];
  assign in_key = s_axis_tdata[73:10] & KMASK;
  assign in_link_val = s_axis_tdata[84:74];
  assign hit = (rd_key == key);
  assign empty = (rd_key == '0);

  always_comb begin
    if (primary_slots == '0) k = PW'(1);
    else if (32'(primary_slots) > TABLE_SIZE) k = PW'(TABLE_SIZE);
    else k = PW'(primary_slots);
  end

  fdh_mod #(.DW(33), .MW(PW)) u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .dividend(h1), .divisor(k),
    .ctl(mctl), .remainder(mrem)
  );

  always_comb begin
    state_next = state;
    case (state)
      fdh_pkg::ST_CLEAR: if (32'(clr) == TABLE_SIZE - 1) state_next = fdh_pkg::ST_IDLE;
      fdh_pkg::ST_IDLE:
        if (s_axis_tvalid && s_axis_tready && s_axis_tuser == fdh_pkg::REQ_LOOKUP)
          state_next = (in_key == '0) ? fdh_pkg::ST_DONE : fdh_pkg::ST_HASH;
      fdh_pkg::ST_HASH: if (32'(bcnt) == KEY_BYTES - 1) state_next = fdh_pkg::ST_MOD1;
      fdh_pkg::ST_MOD1: if (!mod_start && !mctl.busy) state_next = fdh_pkg::ST_RD;
      fdh_pkg::ST_RD: state_next = fdh_pkg::ST_CHK;
      fdh_pkg::ST_CHK: begin
        if (hit || empty) state_next = fdh_pkg::ST_DONE;
        else if (!in_link) state_next = fdh_pkg::ST_STEP;
        else if (rd_link == '0 || 32'(rd_link) > TABLE_SIZE ||
                 32'(cnt) == TABLE_SIZE) state_next = fdh_pkg::ST_DONE;
        else state_next = fdh_pkg::ST_RD;
      end
      fdh_pkg::ST_STEP: state_next = fdh_pkg::ST_MOD2;
      fdh_pkg::ST_MOD2: if (!mod_start && !mctl.busy) state_next = fdh_pkg::ST_RD;
      fdh_pkg::ST_DONE: if (m_axis_tvalid && m_axis_tready) state_next = fdh_pkg::ST_IDLE;
      default: state_next = fdh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == fdh_pkg::ST_IDLE);
    m_axis_tvalid = (state == fdh_pkg::ST_DONE);
    m_axis_tdata = {5'd0, result};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fdh_pkg::ST_CLEAR;
      clr <= '0;
      primary_slots <= 11'd1024;
      mod_start <= 1'b0;
    end else begin
      state <= state_next;
      mod_start <= 1'b0;
      if (cfg_wr_en) primary_slots <= cfg_wr_data;
      case (state)
        fdh_pkg::ST_CLEAR: begin
          clr <= clr + 1'b1;
          key_mem[clr] <= '0;
          link_mem[clr] <= '0;
        end
        fdh_pkg::ST_IDLE: if (s_axis_tvalid) begin
          if (s_axis_tuser == fdh_pkg::REQ_WRITE) begin
            if (32'(in_slot) < TABLE_SIZE) begin
              key_mem[AW'(in_slot)] <= in_key;
              link_mem[AW'(in_slot)] <= in_link_val;
            end
          end else begin
            key <= in_key;
            h <= fdh_pkg::FNV_OFFSET;
            bcnt <= '0;
            result <= '0;
          end
        end
        fdh_pkg::ST_HASH: begin
          h <= (h * fdh_pkg::FNV_PRIME) ^ {24'd0, key[8*bcnt +: 8]};
          bcnt <= bcnt + 1'b1;
          if (32'(bcnt) == KEY_BYTES - 1) begin
            h1 <= {1'b0, (h * fdh_pkg::FNV_PRIME) ^ {24'd0, key[8*bcnt +: 8]}};
            mod_start <= 1'b1;
          end
        end
        fdh_pkg::ST_MOD1: if (!mod_start && !mctl.busy) begin
          h1 <= {{(33-PW){1'b0}}, mrem};
          h2 <= mrem | PW'(1);
          p <= mrem;
          cnt <= '0;
          in_link <= 1'b0;
        end
        fdh_pkg::ST_RD: begin
          rd_key <= key_mem[AW'(p)];
          rd_link <= link_mem[AW'(p)];
        end
        fdh_pkg::ST_CHK: begin
          if (hit) result <= 11'(p) + 11'd1;
          else if (!empty && in_link) begin
            p <= PW'(rd_link - 11'd1);
            cnt <= cnt + 1'b1;
          end
        end
        fdh_pkg::ST_STEP: begin
          // h1 stays below 2^32 since it grows by at most TABLE_SIZE per probe
          h1 <= h1 + 33'(h2);
          mod_start <= 1'b1;
        end
        fdh_pkg::ST_MOD2: if (!mod_start && !mctl.busy) begin
          p <= mrem;
          if (cnt == k - 1'b1) begin
            in_link <= 1'b1;
            cnt <= '0;
          end else cnt <= cnt + 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- design/fdh_checker.sv -----
// Port-level checks for the hash lookup core, bound to the top level.
`default_nettype none
`include "fnv_double_hash_table_lookup_core_defines.svh"
module fdh_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);
  logic m_stall;

  assign m_stall = m_axis_tvalid && !m_axis_tready;

  `FDH_ASSERT_IMP(a_excl, clk, rst, m_axis_tvalid, !s_axis_tready)
  `FDH_ASSERT_NXT(a_hold, clk, rst, m_stall, m_axis_tvalid && $stable(m_axis_tdata))
  `FDH_ASSERT_IMP(a_range, clk, rst, m_axis_tvalid, m_axis_tdata <= 16'd1024)
endmodule
bind fnv_double_hash_table_lookup_core fdh_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
